>>> rtl/core/rotation_matrix_to_euler_angles_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation-matrix-to-Euler-angles block
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH

// Clocked assertion, quiet while reset is asserted
`define RMTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define RMTE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rmte_pkg.sv
// ----------------------------------------------------------------------------
// rmte_pkg
// Shared constants, register codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rmte_pkg;

  localparam int ELEM_W_DEF        = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PRE_SHIFT         = 14;   // operands scaled by 2^14
  localparam int ZFW               = 26;   // angle accumulator, deg*65536
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 11;
  localparam int ROLL_W            = 16;
  localparam int PITCH_W           = 15;

  localparam logic signed [ZFW-1:0] DEG90_FINE   = 26'sd5898240;
  localparam logic signed [ZFW-1:0] ROUND_HALF   = 26'sd256;
  localparam logic signed [ZFW-1:0] HALF_TURN    = 26'sd23040;
  localparam logic signed [ZFW-1:0] QUARTER_TURN = 26'sd11520;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONVENTION    = 1'b0,
    REG_GIMBAL_MARGIN = 1'b1
  } cfg_reg_t;

  localparam logic CONV_ZYX = 1'b0;
  localparam logic CONV_XYZ = 1'b1;

  // atan(2^-i) in deg*65536, rounded
  function automatic logic signed [ZFW-1:0] atan_fine(input int i);
    logic signed [ZFW-1:0] a;
    case (i)
      0:       a = 26'sd2949120;
      1:       a = 26'sd1740967;
      2:       a = 26'sd919879;
      3:       a = 26'sd466945;
      4:       a = 26'sd234379;
      5:       a = 26'sd117304;
      6:       a = 26'sd58666;
      7:       a = 26'sd29335;
      8:       a = 26'sd14668;
      9:       a = 26'sd7334;
      10:      a = 26'sd3667;
      11:      a = 26'sd1833;
      12:      a = 26'sd917;
      13:      a = 26'sd458;
      14:      a = 26'sd229;
      15:      a = 26'sd115;
      16:      a = 26'sd57;
      17:      a = 26'sd29;
      18:      a = 26'sd14;
      19:      a = 26'sd7;
      20:      a = 26'sd4;
      21:      a = 26'sd2;
      22:      a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/rmte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmte_sqrt_cell
// One result bit of the integer square root; side data rides along.
// ----------------------------------------------------------------------------
module rmte_sqrt_cell #(
  parameter int RW     = 15,
  parameter int K      = 0,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW+1:0]     rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  import rmte_pkg::*;

  logic [2*RW-1:0]   rad_r;
  logic [RW+1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [RW+1:0]     cur, trial;

  // remainder stays below 2^RW before the shift
  always_comb begin
    cur   = {rem_i[RW-1:0], rad_i[2*K+1 -: 2]};
    trial = {root_i, 2'b01};
    if (cur >= trial) begin
      rem_nxt  = cur - trial;
      root_nxt = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = cur;
      root_nxt = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

>>> rtl/core/rmte_cordic_cell.sv
// ----------------------------------------------------------------------------
// rmte_cordic_cell
// One vectoring micro-rotation of the atan2 CORDIC.
// ----------------------------------------------------------------------------
module rmte_cordic_cell #(
  parameter int XW = 34,
  parameter int I  = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [XW-1:0]           x_i,
  input  logic signed [XW-1:0]           y_i,
  input  logic signed [rmte_pkg::ZFW-1:0] z_i,
  output logic signed [XW-1:0]           x_o,
  output logic signed [XW-1:0]           y_o,
  output logic signed [rmte_pkg::ZFW-1:0] z_o
);
  import rmte_pkg::*;

  logic signed [XW-1:0]  x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ZFW-1:0] z_r, z_nxt;

  always_comb begin
    xs = x_i >>> I;
    ys = y_i >>> I;
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + atan_fine(I);
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - atan_fine(I);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> rtl/core/rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles
// Q1.14 rotation matrix to roll, pitch and yaw (deg*128) with gimbal flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  in_      | in        | in_valid/in_stall  | in_m00 .. in_m22
//  out_     | out       | out_valid/out_stall| roll, pitch, yaw, gimbal_lock
//  cfg_     | in        | cfg_we             | cfg_index, cfg_data
//
//  One beat enters per cycle while the pipe is not frozen. The stages are
//  select/clamp, square, ELEMENT_WIDTH-1 square-root cells, the quadrant
//  stage, CORDIC_STAGES rotation cells and the output register.
//  The whole pipe moves on one enable; it freezes only while a held result
//  is stalled, and in_stall is that same condition.
//  Reset (rst_n, synchronous) clears valid bits and sets config to ZYX, margin 1.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles #(
  parameter int ELEMENT_WIDTH = rmte_pkg::ELEM_W_DEF,
  parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rmte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmte_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m00,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m01,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m02,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m10,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m11,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m12,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m20,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m21,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_m22,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmte_pkg::ROLL_W-1:0]  out_roll_deg,
  output logic signed [rmte_pkg::PITCH_W-1:0] out_pitch_deg,
  output logic signed [rmte_pkg::ROLL_W-1:0]  out_yaw_deg,
  output logic                                out_gimbal_lock
);
  import rmte_pkg::*;

  localparam int W      = ELEMENT_WIDTH;
  localparam int RW     = W - 1;              // root bits, root <= 2^(W-2)
  localparam int NW     = 2 * RW;             // radicand bits
  localparam int XW     = W + 18;             // CORDIC datapath
  localparam int LW     = ((W > CFG_DATA_W) ? W : CFG_DATA_W) + 2;
  localparam int SIDE_W = 1 + W + 4 * (W + 1);
  localparam int NV     = RW + 3 + CORDIC_STAGES;

  localparam logic signed [W:0]     ONE_S  = {2'b00, 1'b1, {(W-2){1'b0}}};
  localparam logic signed [2*W-1:0] ONE_SQ = {4'b0001, {(2*W-4){1'b0}}};

  // ---------------- configuration ----------------
  logic                  conv_r;
  logic [CFG_DATA_W-1:0] margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r   <= CONV_ZYX;
      margin_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONVENTION:    conv_r   <= cfg_data[0];
        REG_GIMBAL_MARGIN: margin_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // ---------------- pipe enable and valid bits ----------------
  logic          en;
  logic [NV-1:0] v_r;
  logic          out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NV-2:0], in_valid};
      out_valid_r <= v_r[NV-1];
    end
  end

  // ---------------- stage A: sine select, clamp, lock, operand pick ----
  logic signed [W:0]    e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [W:0]    s_raw, s_cl, mag;
  logic signed [LW-1:0] thr;
  logic                 lock;
  logic signed [W:0]    ry, rx, yy, yx;

  always_comb begin
    e00 = (W+1)'(in_m00); e01 = (W+1)'(in_m01); e02 = (W+1)'(in_m02);
    e10 = (W+1)'(in_m10); e11 = (W+1)'(in_m11); e12 = (W+1)'(in_m12);
    e20 = (W+1)'(in_m20); e21 = (W+1)'(in_m21); e22 = (W+1)'(in_m22);
    s_raw = (conv_r == CONV_XYZ) ? e02 : -e20;
    if (s_raw > ONE_S)       s_cl = ONE_S;
    else if (s_raw < -ONE_S) s_cl = -ONE_S;
    else                     s_cl = s_raw;
    mag  = s_cl[W] ? -s_cl : s_cl;
    thr  = LW'(ONE_S) - LW'($signed({1'b0, margin_r}));
    lock = LW'(mag) >= thr;
    // a zero pair is flagged and its angle forced to 0 at the rounding stage
    if (conv_r == CONV_ZYX) begin
      if (!lock) begin
        ry = e21;  rx = e22;  yy = e10;  yx = e00;
      end else begin
        ry = '0;   rx = '0;   yy = -e01; yx = e11;
      end
    end else begin
      if (!lock) begin
        ry = -e12; rx = e22;  yy = -e01; yx = e00;
      end else begin
        ry = e21;  rx = e11;  yy = '0;   yx = '0;
      end
    end
  end

  logic signed [W-1:0] a_s_r;
  logic signed [W:0]   a_ry_r, a_rx_r, a_yy_r, a_yx_r;
  logic                a_lock_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_s_r    <= W'(s_cl);
      a_ry_r   <= ry;
      a_rx_r   <= rx;
      a_yy_r   <= yy;
      a_yx_r   <= yx;
      a_lock_r <= lock;
    end
  end

  // ---------------- stage B: radicand one^2 - s^2 ----------------
  logic signed [2*W-1:0] sq;
  logic [NW-1:0]         b_rad_r;
  logic [SIDE_W-1:0]     b_side_r;

  assign sq = (2*W)'(a_s_r) * (2*W)'(a_s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      b_rad_r  <= NW'(ONE_SQ - sq);
      b_side_r <= {a_lock_r, a_s_r, a_ry_r, a_rx_r, a_yy_r, a_yx_r};
    end
  end

  // ---------------- square root chain, one bit per cell ----------------
  logic [NW-1:0]     rad_w  [RW+1];
  logic [RW+1:0]     rem_w  [RW+1];
  logic [RW-1:0]     root_w [RW+1];
  logic [SIDE_W-1:0] side_w [RW+1];

  assign rad_w[0]  = b_rad_r;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = b_side_r;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    rmte_sqrt_cell #(.RW(RW), .K(RW - 1 - j), .SIDE_W(SIDE_W)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_w[j]),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .side_i (side_w[j]),
      .rad_o  (rad_w[j+1]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1]),
      .side_o (side_w[j+1])
    );
  end

  // ---------------- quadrant stage: lanes roll, pitch, yaw ----------------
  logic              q_lock;
  logic signed [W-1:0] q_s;
  logic signed [W:0] lane_y [3];
  logic signed [W:0] lane_x [3];

  assign {q_lock, q_s, lane_y[0], lane_x[0], lane_y[2], lane_x[2]} = side_w[RW];
  assign lane_y[1] = (W+1)'(q_s);
  assign lane_x[1] = $signed({2'b00, root_w[RW]});

  logic signed [XW-1:0]  cx [3][CORDIC_STAGES+1];
  logic signed [XW-1:0]  cy [3][CORDIC_STAGES+1];
  logic signed [ZFW-1:0] cz [3][CORDIC_STAGES+1];
  logic [3:0]            fl_r [CORDIC_STAGES+1];   // {lock, zero per lane}
  logic [2:0]            zero;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [W+1:0]   ey, ex, px, py;
    logic signed [ZFW-1:0] pz;
    logic signed [XW-1:0]  p_x_r, p_y_r;
    logic signed [ZFW-1:0] p_z_r;

    // negative x: turn by a quarter so the vector sits in the right half
    always_comb begin
      ey = (W+2)'(lane_y[g]);
      ex = (W+2)'(lane_x[g]);
      zero[g] = (ey == '0) && (ex == '0);
      if (ex[W+1]) begin
        if (!ey[W+1]) begin
          px = ey;  py = -ex; pz = DEG90_FINE;
        end else begin
          px = -ey; py = ex;  pz = -DEG90_FINE;
        end
      end else begin
        px = ex;  py = ey;  pz = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_x_r <= XW'(px) <<< PRE_SHIFT;
        p_y_r <= XW'(py) <<< PRE_SHIFT;
        p_z_r <= pz;
      end
    end

    assign cx[g][0] = p_x_r;
    assign cy[g][0] = p_y_r;
    assign cz[g][0] = p_z_r;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      rmte_cordic_cell #(.XW(XW), .I(i)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (cx[g][i]),
        .y_i (cy[g][i]),
        .z_i (cz[g][i]),
        .x_o (cx[g][i+1]),
        .y_o (cy[g][i+1]),
        .z_o (cz[g][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= {q_lock, zero};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1] <= fl_r[i];
      end
    end
  end

  // ---------------- round to deg*128, clamp, output register ----------------
  logic signed [ZFW-1:0] zr  [3];
  logic signed [ZFW-1:0] ang [3];

  for (genvar g = 0; g < 3; g++) begin : g_round
    always_comb begin
      zr[g] = (cz[g][CORDIC_STAGES] + ROUND_HALF) >>> 9;
      if (fl_r[CORDIC_STAGES][g])   ang[g] = '0;
      else if (zr[g] > HALF_TURN)   ang[g] = HALF_TURN;
      else if (zr[g] < -HALF_TURN)  ang[g] = -HALF_TURN;
      else                          ang[g] = zr[g];
    end
  end

  logic signed [ZFW-1:0]     pitch_cl;
  logic signed [ROLL_W-1:0]  roll_r, yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic                      lock_r;

  always_comb begin
    if (ang[1] > QUARTER_TURN)       pitch_cl = QUARTER_TURN;
    else if (ang[1] < -QUARTER_TURN) pitch_cl = -QUARTER_TURN;
    else                             pitch_cl = ang[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ROLL_W'(ang[0]);
      pitch_r <= PITCH_W'(pitch_cl);
      yaw_r   <= ROLL_W'(ang[2]);
      lock_r  <= fl_r[CORDIC_STAGES][3];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_deg    = roll_r;
  assign out_pitch_deg   = pitch_r;
  assign out_yaw_deg     = yaw_r;
  assign out_gimbal_lock = lock_r;

endmodule

>>> rtl/core/rmte_checker.sv
// ----------------------------------------------------------------------------
// rmte_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_euler_angles_macros.svh"

module rmte_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [rmte_pkg::ROLL_W-1:0]  out_roll_deg,
  input logic signed [rmte_pkg::PITCH_W-1:0] out_pitch_deg,
  input logic signed [rmte_pkg::ROLL_W-1:0]  out_yaw_deg,
  input logic                                out_gimbal_lock
);
  import rmte_pkg::*;

  `RMTE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  `RMTE_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_roll_deg) && $stable(out_pitch_deg) && $stable(out_yaw_deg) && $stable(out_gimbal_lock), "stalled result changed")

  `RMTE_ASSERT(a_pitch_range, clk, rst_n, out_valid |-> (out_pitch_deg <= 15'sd11520) && (out_pitch_deg >= -15'sd11520), "pitch beyond a quarter turn")

  `RMTE_ASSERT(a_turn_range, clk, rst_n, out_valid |-> (out_roll_deg <= 16'sd23040) && (out_roll_deg >= -16'sd23040) && (out_yaw_deg <= 16'sd23040) && (out_yaw_deg >= -16'sd23040), "roll or yaw beyond a half turn")

endmodule

bind rotation_matrix_to_euler_angles rmte_checker u_rmte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_roll_deg    (out_roll_deg),
  .out_pitch_deg   (out_pitch_deg),
  .out_yaw_deg     (out_yaw_deg),
  .out_gimbal_lock (out_gimbal_lock)
);
